// ===== sv/svd_pkg.sv =====
package svd_pkg;

  localparam int MAX_STATES_D   = 64;
  localparam int MAX_DEPTH_D    = 64;
  localparam int CODE_RATE_D    = 2;
  localparam int METRIC_WIDTH_D = 32;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONSTRAINT = 3'd0,
    REG_POLY_FIRST = 3'd1,
    REG_POLY_SECOND = 3'd2,
    REG_TB_DEPTH = 3'd3,
    REG_REL_EN = 3'd4,
    REG_SINGLE = 3'd5
  } cfg_reg_t;

  // Symbol request passed from the front end to the back end.
  typedef struct packed {
    logic signed [7:0] sample_a;
    logic signed [7:0] sample_b;
    logic              block_end;
  } sym_req_t;

  // Squared distance of a Q2.5 sample to +1.0 or -1.0.
  function automatic logic [14:0] sq_dist(input logic signed [7:0] s, input logic bit_v);
    logic signed [8:0] d;
    logic [7:0] a;
    d = bit_v ? ({s[7], s} - 9'sd32) : ({s[7], s} + 9'sd32);
    a = d[8] ? 8'(-d) : d[7:0];
    return {7'd0, a} * {7'd0, a};
  endfunction

endpackage

// ===== sv/svd_ram.sv =====
module svd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/svd_front.sv =====
module svd_front import svd_pkg::*; #(
  parameter int QDEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sym_req_t in_req,
  output logic     q_valid,
  output sym_req_t q_req,
  input  logic     q_pop
);

  localparam int PW = $clog2(QDEPTH);

  sym_req_t          buf_r [QDEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [PW:0]       cnt_r;
  logic              push;

  assign in_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = buf_r[rp_r];

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_req;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop && q_valid);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH)) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PW+1)'(QDEPTH)) |-> in_stall) else $error("full queue not stalled");
`endif

endmodule

// ===== sv/svd_back.sv =====
module svd_back import svd_pkg::*; #(
  parameter int MAX_STATES   = MAX_STATES_D,
  parameter int MAX_DEPTH    = MAX_DEPTH_D,
  parameter int CODE_RATE    = CODE_RATE_D,
  parameter int METRIC_WIDTH = METRIC_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  sym_req_t    q_req,
  output logic        q_pop,
  input  logic [2:0]  cfg_k,
  input  logic [6:0]  cfg_pa,
  input  logic [6:0]  cfg_pb,
  input  logic [6:0]  cfg_depth,
  input  logic        cfg_rel,
  input  logic        cfg_single,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_decoded_bit,
  output logic        out_last_bit,
  output logic [31:0] out_best_metric,
  output logic [31:0] out_reliability
);

  localparam int SW = (MAX_STATES > 2) ? $clog2(MAX_STATES) : 1;
  localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = DW + 1;
  localparam int KMAX = $clog2(MAX_STATES + 1);
  localparam logic [METRIC_WIDTH-1:0] MMAX = '1;

  typedef enum logic [4:0] {
    ST_ACS  = 5'b00001,
    ST_BEST = 5'b00010,
    ST_SEC  = 5'b00100,
    ST_TB   = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [METRIC_WIDTH-1:0] pm_r [MAX_STATES];
  logic [MAX_STATES-1:0]   dec_w;
  logic [METRIC_WIDTH-1:0] nxt_w [MAX_STATES];
  logic [DW-1:0]           wp_r;
  logic [6:0]              steps_r;
  logic [SW:0]             scan_r;
  logic [SW-1:0]           best_r;
  logic [METRIC_WIDTH-1:0] bestm_r, second_r;
  logic [CW-1:0]           n_r, i_r;
  logic [SW-1:0]           st_r;
  logic [MAX_DEPTH-1:0]    bits_r;
  logic [MAX_STATES-1:0]   ring_rd;
  logic [DW-1:0]           ring_ra;
  logic [CW:0]             ra_sum;
  logic                    ring_pend_r;
  logic [2:0]              k_eff;
  logic [SW:0]             ns;
  logic [SW-1:0]           high;
  logic [6:0]              depth_eff;
  logic                    two;
  logic [CW-1:0]           ecnt_r;

  // Effective code parameters.
  always_comb begin
    k_eff = (cfg_k < 3'd2) ? 3'd2 : cfg_k;
    if (32'(k_eff) > KMAX) k_eff = 3'(KMAX);
    ns   = (SW+1)'(1) << (k_eff - 3'd1);
    high = SW'(ns >> 1);
    depth_eff = (cfg_depth == 7'd0) ? 7'd1 :
                (32'(cfg_depth) > MAX_DEPTH) ? 7'(MAX_DEPTH) : cfg_depth;
    two = (CODE_RATE == 2) && !cfg_single;
  end

  // Add-compare-select array, one step per symbol.
  always_comb begin
    for (int s = 0; s < MAX_STATES; s++) begin
      logic [METRIC_WIDTH-1:0] c0, c1;
      logic [KMAX-1:0] p0, p1, r0, r1, rm;
      logic [15:0] b0, b1;
      logic [METRIC_WIDTH:0] t0, t1;
      rm = KMAX'((8'd1 << k_eff) - 8'd1);
      p0 = KMAX'(s >> 1);
      p1 = p0 | KMAX'(high);
      r0 = KMAX'({p0, s[0]}) & rm;
      r1 = KMAX'({p1, s[0]}) & rm;
      b0 = {1'b0, sq_dist(q_req.sample_a, ^(r0 & KMAX'(cfg_pa)))};
      b1 = {1'b0, sq_dist(q_req.sample_a, ^(r1 & KMAX'(cfg_pa)))};
      if (two) begin
        b0 = b0 + {1'b0, sq_dist(q_req.sample_b, ^(r0 & KMAX'(cfg_pb)))};
        b1 = b1 + {1'b0, sq_dist(q_req.sample_b, ^(r1 & KMAX'(cfg_pb)))};
      end
      t0 = {1'b0, pm_r[p0[SW-1:0]]} + (METRIC_WIDTH+1)'(b0);
      t1 = {1'b0, pm_r[p1[SW-1:0]]} + (METRIC_WIDTH+1)'(b1);
      c0 = t0[METRIC_WIDTH] ? MMAX : t0[METRIC_WIDTH-1:0];
      c1 = t1[METRIC_WIDTH] ? MMAX : t1[METRIC_WIDTH-1:0];
      dec_w[s] = (c1 < c0) && ((SW+1)'(s) < ns);
      nxt_w[s] = (c1 < c0) ? c1 : c0;
    end
  end

  logic acs_go;
  assign acs_go = (state_r == ST_ACS) && q_valid;
  assign q_pop  = acs_go;

  // Survivor ring memory; read address wraps modulo the ring depth.
  assign ra_sum  = (CW+1)'(wp_r) + (CW+1)'(MAX_DEPTH) - (CW+1)'(i_r) - (CW+1)'(1);
  assign ring_ra = (ra_sum >= (CW+1)'(MAX_DEPTH)) ? DW'(ra_sum - (CW+1)'(MAX_DEPTH))
                                                  : DW'(ra_sum);
  svd_ram #(.WIDTH(MAX_STATES), .DEPTH(1 << DW)) u_ring (
    .clk(clk), .we(acs_go), .waddr(wp_r), .wdata(dec_w),
    .raddr(ring_ra), .rdata(ring_rd)
  );

  // Output register.
  logic emit_take;
  assign emit_take = out_valid && !out_stall;
  assign out_decoded_bit = bits_r[DW'(ecnt_r - CW'(1))];
  assign out_last_bit    = (ecnt_r == CW'(1));
  assign out_best_metric = (METRIC_WIDTH > 32 && |(64'(bestm_r) >> 32)) ? '1 : 32'(bestm_r);
  assign out_reliability = !cfg_rel ? 32'd0 :
    ((METRIC_WIDTH > 32 && |(64'(second_r - bestm_r) >> 32)) ? '1 : 32'(second_r - bestm_r));
  assign out_valid = (state_r == ST_EMIT) && (ecnt_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACS:  if (acs_go && q_req.block_end) state_nxt = ST_BEST;
      ST_BEST: if (scan_r == ns) state_nxt = ST_SEC;
      ST_SEC:  if (scan_r == ns) state_nxt = ST_TB;
      ST_TB:   if (ring_pend_r && i_r == n_r - CW'(1)) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_take && ecnt_r == CW'(1)) state_nxt = ST_ACS;
      default: state_nxt = ST_ACS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACS;
      wp_r <= '0;
      steps_r <= '0;
      ecnt_r <= '0;
      ring_pend_r <= 1'b0;
      for (int s = 0; s < MAX_STATES; s++) pm_r[s] <= (s == 0) ? '0 : MMAX;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_ACS: begin
          if (acs_go) begin
            for (int s = 0; s < MAX_STATES; s++)
              if ((SW+1)'(s) < ns) pm_r[s] <= nxt_w[s];
            wp_r <= (wp_r == DW'(MAX_DEPTH - 1)) ? '0 : DW'(wp_r + 1'b1);
            steps_r <= (steps_r == 7'd127) ? steps_r : steps_r + 7'd1;
            scan_r <= '0;
            best_r <= '0;
            bestm_r <= MMAX;
            second_r <= MMAX;
          end
        end
        ST_BEST: begin
          // Serial scan for the lowest metric; first wins on ties.
          if (scan_r != ns) begin
            if (scan_r == '0 || pm_r[scan_r[SW-1:0]] < bestm_r) begin
              bestm_r <= pm_r[scan_r[SW-1:0]];
              best_r <= scan_r[SW-1:0];
            end
            scan_r <= scan_r + 1'b1;
          end else begin
            scan_r <= '0;
          end
        end
        ST_SEC: begin
          if (scan_r != ns) begin
            if (scan_r[SW-1:0] != best_r && pm_r[scan_r[SW-1:0]] < second_r)
              second_r <= pm_r[scan_r[SW-1:0]];
            scan_r <= scan_r + 1'b1;
          end else begin
            n_r <= CW'((steps_r < depth_eff) ? steps_r : depth_eff);
            i_r <= '0;
            st_r <= best_r;
            ring_pend_r <= 1'b0;
          end
        end
        ST_TB: begin
          // One ring read per step; the registered read data is used in the cycle after.
          if (!ring_pend_r) begin
            ring_pend_r <= 1'b1;
          end else begin
            bits_r[DW'(i_r)] <= st_r[0];
            st_r <= ((st_r >> 1) | (ring_rd[st_r] ? high : SW'(0))) & SW'(ns - 1'b1);
            ring_pend_r <= 1'b0;
            if (i_r == n_r - CW'(1)) ecnt_r <= n_r;
            else i_r <= i_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_take) begin
            ecnt_r <= ecnt_r - 1'b1;
            if (ecnt_r == CW'(1)) begin
              for (int s = 0; s < MAX_STATES; s++) pm_r[s] <= (s == 0) ? '0 : MMAX;
              steps_r <= '0;
              wp_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_acs: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_ACS) else $error("pop outside ACS");
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ecnt_r <= n_r) else $error("emit count above block length");
  a_best_le_second: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TB |-> bestm_r <= second_r) else $error("best above second");
`endif

endmodule

// ===== sv/soft_viterbi_decoder_top.sv =====
// Soft-decision Viterbi decoder, rate 1/2 (rate 1 in single mode), K = 2..7.
// Throughput: one symbol per cycle through the ACS array while in state ACS.
// At block end: best and second-best metric scans over the S states, an N-step
// traceback with one ring read per step, then N output requests, one per cycle
// while out_stall is low; N = min(steps, depth).
// Synchronous active-low reset restores default registers and path metrics.
module soft_viterbi_decoder_top import svd_pkg::*; #(
  parameter int MAX_STATES   = MAX_STATES_D,
  parameter int MAX_DEPTH    = MAX_DEPTH_D,
  parameter int CODE_RATE    = CODE_RATE_D,
  parameter int METRIC_WIDTH = METRIC_WIDTH_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_sample_a,
  input  logic signed [7:0] in_sample_b,
  input  logic              in_block_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_decoded_bit,
  output logic              out_last_bit,
  output logic [31:0]       out_best_metric,
  output logic [31:0]       out_reliability,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data
);

  logic [2:0] k_r;
  logic [6:0] pa_r, pb_r, depth_r;
  logic       rel_r, single_r;
  sym_req_t   in_req, q_req;
  logic       q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 3'd7;
      pa_r <= 7'd91;
      pb_r <= 7'd121;
      depth_r <= 7'd40;
      rel_r <= 1'b0;
      single_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONSTRAINT:  k_r <= cfg_data[2:0];
        REG_POLY_FIRST:  pa_r <= cfg_data;
        REG_POLY_SECOND: pb_r <= cfg_data;
        REG_TB_DEPTH:    depth_r <= cfg_data;
        REG_REL_EN:      rel_r <= cfg_data[0];
        REG_SINGLE:      single_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_req = '{sample_a: in_sample_a, sample_b: in_sample_b, block_end: in_block_end};

  svd_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req,
    .q_valid, .q_req, .q_pop
  );

  svd_back #(.MAX_STATES(MAX_STATES), .MAX_DEPTH(MAX_DEPTH),
             .CODE_RATE(CODE_RATE), .METRIC_WIDTH(METRIC_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop,
    .cfg_k(k_r), .cfg_pa(pa_r), .cfg_pb(pb_r), .cfg_depth(depth_r),
    .cfg_rel(rel_r), .cfg_single(single_r),
    .out_valid, .out_stall, .out_decoded_bit, .out_last_bit,
    .out_best_metric, .out_reliability
  );

endmodule
